// File: design/dgsp_pkg.sv
// ============================================================================
// dgsp_pkg - shared types and constants of the shortest path unit
// Field widths, request codes, sequencer states and inter-module structs.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dgsp_pkg;

    // Payload field widths
    localparam int NODE_FIELD_BITS   = 6;
    localparam int WEIGHT_FIELD_BITS = 16;
    localparam int DIST_BITS         = 22;

    // Route output limit and distance saturation point
    localparam int MAX_RESULTS = 64;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    // Request codes
    localparam logic CMD_WRITE = 1'b0;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_DECIDE,
        ST_RELAX,
        ST_PROBE,
        ST_WALK,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_NONE
    } dgsp_state_t;

    // Minimum scan control
    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctrl_t;

    // Relaxation decision for one neighbor
    typedef struct packed {
        logic                 update;
        logic [DIST_BITS-1:0] new_dist;
    } relax_res_t;

endpackage

`default_nettype wire

// File: design/dgsp_if.sv
// ============================================================================
// dgsp_if - request and response channels of the shortest path unit
// Valid/ready channels; a request moves when valid and ready are both high.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface dgsp_req_if
    import dgsp_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [NODE_FIELD_BITS-1:0]   from_node;
    logic [NODE_FIELD_BITS-1:0]   to_node;
    logic [WEIGHT_FIELD_BITS-1:0] edge_weight;

    modport source (output valid, output cmd, output from_node, output to_node,
                    output edge_weight, input ready);
    modport sink   (input valid, input cmd, input from_node, input to_node,
                    input edge_weight, output ready);
endinterface

interface dgsp_rsp_if
    import dgsp_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [NODE_FIELD_BITS-1:0] path_node;
    logic [DIST_BITS-1:0]       total_distance;
    logic                       reachable;
    logic                       last;

    modport source (output valid, output path_node, output total_distance,
                    output reachable, output last, input ready);
    modport sink   (input valid, input path_node, input total_distance,
                    input reachable, input last, output ready);
endinterface

`default_nettype wire

// File: design/dense_graph_shortest_path_unit.sv
// ============================================================================
// dense_graph_shortest_path_unit - Dijkstra over a dense weight matrix
// Edge writes, shortest-path queries, route streamed start to end.
// ============================================================================
// After reset the unit sweeps the weight matrix once, one word a cycle
// (diagonal 0, all else "no link"), and takes no request until that is
// done. An edge write goes straight into the matrix. A query first sets up
// the node table, then per visited node sweeps the table to find the nearest
// open node and sweeps that node's matrix row to relax its neighbors; the
// single read port of the node table paces both sweeps. The route is then
// walked back station by station and streamed out start first, one station
// at a time while the sink is ready. A new request is taken while the final
// result still waits.
`timescale 1ns / 1ps
`default_nettype none

module dense_graph_shortest_path_unit
    import dgsp_pkg::*;
#(
    parameter int NODE_COUNT  = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dgsp_req_if.sink   req,
    dgsp_rsp_if.source rsp
);

    localparam int NB = $clog2(NODE_COUNT);
    localparam int CW = $clog2(NODE_COUNT + 1);
    localparam int RW = $clog2(MAX_RESULTS + 1);
    localparam int NW = 2 + DIST_BITS + NB;
    localparam logic [NB-1:0]          LAST_NODE = NB'(NODE_COUNT - 1);
    localparam logic [WEIGHT_BITS-1:0] NO_LINK   = '1;

    typedef struct packed {
        logic                 reached;
        logic                 done;
        logic [DIST_BITS-1:0] distance;
        logic [NB-1:0]        pred;
    } node_entry_t;

    // sequencer state
    dgsp_state_t state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [2*NB-1:0]      clr_reg, clr_next;
    logic                 pv_reg, pv_next;
    logic [NB-1:0]        pidx_reg, pidx_next;
    logic [NB-1:0]        a_reg, a_next;
    logic [NB-1:0]        b_reg, b_next;
    logic [NB-1:0]        n_reg, n_next;
    logic [CW-1:0]        len_reg, len_next;
    logic [NB-1:0]        ptr_reg, ptr_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [DIST_BITS-1:0] total_reg, total_next;

    // response register
    logic                       rsp_valid_reg, rsp_valid_next;
    logic [NODE_FIELD_BITS-1:0] rsp_node_reg;
    logic [DIST_BITS-1:0]       rsp_dist_reg;
    logic                       rsp_reach_reg;
    logic                       rsp_last_reg;
    logic                       out_load;
    logic [NODE_FIELD_BITS-1:0] out_node;
    logic [DIST_BITS-1:0]       out_dist;
    logic                       out_reach;
    logic                       out_last;
    logic                       out_free;

    // memory ports
    logic                   mat_we, mat_re;
    logic [2*NB-1:0]        mat_waddr, mat_raddr;
    logic [WEIGHT_BITS-1:0] mat_wdata, mat_rdata;
    logic                   node_we, node_re;
    logic [NB-1:0]          node_waddr, node_raddr;
    node_entry_t            node_wr, node_rd;
    logic [NW-1:0]          node_rdata;
    logic                   stk_we, stk_re;
    logic [NB-1:0]          stk_waddr, stk_raddr, stk_rdata;

    // datapath helpers
    scan_ctrl_t             scan_ctrl;
    logic                   scan_found;
    logic [DIST_BITS-1:0]   scan_best;
    logic [NB-1:0]          scan_idx;
    logic [NB-1:0]          scan_pred;
    relax_res_t             relax_res;
    logic                   relax_skip;
    logic                   req_in_range;
    logic [NB-1:0]          req_from_idx, req_to_idx;
    logic [CW-1:0]          len_plus;

    assign node_rd      = node_entry_t'(node_rdata);
    assign out_free     = !rsp_valid_reg || rsp.ready;
    assign req_in_range = (32'(req.from_node) < NODE_COUNT) && (32'(req.to_node) < NODE_COUNT);
    assign req_from_idx = NB'(req.from_node);
    assign req_to_idx   = NB'(req.to_node);
    assign len_plus     = len_reg + CW'(1);
    assign relax_skip   = (pidx_reg == a_reg) || (pidx_reg == scan_idx);

    // weight matrix, row-major by {from, to}
    dgsp_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (1 << (2 * NB))
    ) u_matrix (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .re    (mat_re),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    // per-node distance, flags and predecessor
    dgsp_ram #(
        .WIDTH (NW),
        .DEPTH (NODE_COUNT)
    ) u_nodes (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wr),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // route stack, end station first
    dgsp_ram #(
        .WIDTH (NB),
        .DEPTH (NODE_COUNT)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (n_reg),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    dgsp_min_scan #(
        .NODE_BITS (NB)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (scan_ctrl),
        .cand_idx     (pidx_reg),
        .cand_reached (node_rd.reached),
        .cand_done    (node_rd.done),
        .cand_dist    (node_rd.distance),
        .cand_pred    (node_rd.pred),
        .found        (scan_found),
        .best_dist    (scan_best),
        .best_idx     (scan_idx),
        .best_pred    (scan_pred)
    );

    dgsp_relax #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_relax (
        .dist_u     (scan_best),
        .weight     (mat_rdata),
        .nb_reached (node_rd.reached),
        .nb_done    (node_rd.done),
        .nb_dist    (node_rd.distance),
        .skip       (relax_skip),
        .res        (relax_res)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            pv_reg        <= 1'b0;
            len_reg       <= '0;
            rem_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            pv_reg        <= pv_next;
            len_reg       <= len_next;
            rem_reg       <= rem_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg  <= pidx_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        n_reg     <= n_next;
        ptr_reg   <= ptr_next;
        total_reg <= total_next;
        if (out_load)
        begin
            rsp_node_reg  <= out_node;
            rsp_dist_reg  <= out_dist;
            rsp_reach_reg <= out_reach;
            rsp_last_reg  <= out_last;
        end
    end

    // next state and memory control
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        pv_next    = 1'b0;
        pidx_next  = pidx_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        n_next     = n_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        rem_next   = rem_reg;
        total_next = total_reg;

        mat_we     = 1'b0;
        mat_waddr  = clr_reg;
        mat_wdata  = NO_LINK;
        mat_re     = 1'b0;
        mat_raddr  = {scan_idx, cnt_reg[NB-1:0]};
        node_we    = 1'b0;
        node_waddr = pidx_reg;
        node_wr    = '0;
        node_re    = 1'b0;
        node_raddr = cnt_reg[NB-1:0];
        stk_we     = 1'b0;
        stk_waddr  = len_reg[NB-1:0];
        stk_re     = 1'b0;
        stk_raddr  = ptr_reg;

        scan_ctrl  = '0;
        out_load   = 1'b0;
        out_node   = '0;
        out_dist   = '0;
        out_reach  = 1'b0;
        out_last   = 1'b0;
        req.ready  = 1'b0;

        case (state_reg)
            // matrix clearing pass after reset
            ST_CLEAR:
            begin
                mat_we    = 1'b1;
                mat_waddr = clr_reg;
                mat_wdata = (clr_reg[2*NB-1:NB] == clr_reg[NB-1:0]) ? '0 : NO_LINK;
                clr_next  = clr_reg + (2*NB)'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (req.cmd == CMD_WRITE)
                    begin
                        mat_we    = req_in_range;
                        mat_waddr = {req_from_idx, req_to_idx};
                        mat_wdata = WEIGHT_BITS'(req.edge_weight);
                    end
                    else
                    begin
                        a_next     = req_from_idx;
                        b_next     = req_to_idx;
                        cnt_next   = '0;
                        state_next = req_in_range ? ST_INIT : ST_NONE;
                    end
                end
            end

            // node table setup, start reached at distance 0
            ST_INIT:
            begin
                node_we          = 1'b1;
                node_waddr       = cnt_reg[NB-1:0];
                node_wr.reached  = (cnt_reg[NB-1:0] == a_reg);
                node_wr.done     = 1'b0;
                node_wr.distance = '0;
                node_wr.pred     = a_reg;
                cnt_next         = cnt_reg + CW'(1);
                if (cnt_reg[NB-1:0] == LAST_NODE)
                begin
                    cnt_next        = '0;
                    scan_ctrl.clear = 1'b1;
                    state_next      = ST_SCAN;
                end
            end

            // sweep for the nearest open node
            ST_SCAN:
            begin
                if (cnt_reg < CW'(NODE_COUNT))
                begin
                    node_re    = 1'b1;
                    node_raddr = cnt_reg[NB-1:0];
                    pv_next    = 1'b1;
                    pidx_next  = cnt_reg[NB-1:0];
                    cnt_next   = cnt_reg + CW'(1);
                end
                if (pv_reg)
                begin
                    scan_ctrl.sample = 1'b1;
                    if (pidx_reg == LAST_NODE)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                if (scan_found)
                begin
                    cnt_next   = '0;
                    state_next = ST_RELAX;
                end
                else
                begin
                    node_re    = 1'b1;
                    node_raddr = b_reg;
                    state_next = ST_PROBE;
                end
            end

            // relax the row of the chosen node; its own entry gets marked done
            ST_RELAX:
            begin
                if (cnt_reg < CW'(NODE_COUNT))
                begin
                    node_re    = 1'b1;
                    node_raddr = cnt_reg[NB-1:0];
                    mat_re     = 1'b1;
                    mat_raddr  = {scan_idx, cnt_reg[NB-1:0]};
                    pv_next    = 1'b1;
                    pidx_next  = cnt_reg[NB-1:0];
                    cnt_next   = cnt_reg + CW'(1);
                end
                if (pv_reg)
                begin
                    node_waddr = pidx_reg;
                    if (pidx_reg == scan_idx)
                    begin
                        node_we          = 1'b1;
                        node_wr.reached  = 1'b1;
                        node_wr.done     = 1'b1;
                        node_wr.distance = scan_best;
                        node_wr.pred     = scan_pred;
                    end
                    else if (relax_res.update)
                    begin
                        node_we          = 1'b1;
                        node_wr.reached  = 1'b1;
                        node_wr.done     = 1'b0;
                        node_wr.distance = relax_res.new_dist;
                        node_wr.pred     = scan_idx;
                    end
                    if (pidx_reg == LAST_NODE)
                    begin
                        cnt_next        = '0;
                        scan_ctrl.clear = 1'b1;
                        state_next      = ST_SCAN;
                    end
                end
            end

            // end station entry is on the read port
            ST_PROBE:
            begin
                if (!node_rd.reached)
                begin
                    state_next = ST_NONE;
                end
                else
                begin
                    total_next = node_rd.distance;
                    n_next     = b_reg;
                    len_next   = '0;
                    state_next = ST_WALK;
                end
            end

            // push station, follow predecessor
            ST_WALK:
            begin
                stk_we    = 1'b1;
                stk_waddr = len_reg[NB-1:0];
                len_next  = len_plus;
                if ((n_reg == a_reg) || (len_reg == CW'(NODE_COUNT - 1)))
                begin
                    rem_next   = (32'(len_plus) < MAX_RESULTS) ? RW'(len_plus)
                                                               : RW'(MAX_RESULTS);
                    ptr_next   = len_reg[NB-1:0];
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    n_next     = node_rd.pred;
                    node_re    = 1'b1;
                    node_raddr = node_rd.pred;
                end
            end

            ST_EMIT_RD:
            begin
                stk_re     = 1'b1;
                stk_raddr  = ptr_reg;
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    out_node  = NODE_FIELD_BITS'(stk_rdata);
                    out_dist  = total_reg;
                    out_reach = 1'b1;
                    out_last  = (rem_reg == RW'(1));
                    if (rem_reg == RW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rem_next   = rem_reg - RW'(1);
                        ptr_next   = ptr_reg - NB'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            // single "no route" result
            ST_NONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_valid_next = out_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
    end

    // response channel
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.path_node      = rsp_node_reg;
    assign rsp.total_distance = rsp_dist_reg;
    assign rsp.reachable      = rsp_reach_reg;
    assign rsp.last           = rsp_last_reg;

`ifndef ASSERT_OFF
    // read-modify-write never reads the entry being written
    a_node_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (node_we && node_re) |-> (node_waddr != node_raddr))
        else $error("node table read and write hit the same entry");

    // relaxation only runs with a chosen node
    a_relax_has_node: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RELAX) |-> scan_found)
        else $error("relax pass without a selected node");

    // route walk stays inside the stack
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (len_reg < CW'(NODE_COUNT)))
        else $error("route walk ran past the stack depth");

    // streaming always has a station left to send
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT_RD) || (state_reg == ST_EMIT_LD)) |-> (rem_reg != '0))
        else $error("route output with no stations left");
`endif

endmodule

`default_nettype wire

// File: design/dgsp_ram.sv
// ============================================================================
// dgsp_ram - generic simple dual-port RAM
// One write port, one read port with read enable and registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dgsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/dgsp_min_scan.sv
// ============================================================================
// dgsp_min_scan - running minimum over the node sweep
// Keeps the unvisited reached node of smallest distance, lowest index on ties.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dgsp_min_scan
    import dgsp_pkg::*;
#(
    parameter int NODE_BITS = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire scan_ctrl_t           ctrl,
    input  wire logic [NODE_BITS-1:0] cand_idx,
    input  wire logic                 cand_reached,
    input  wire logic                 cand_done,
    input  wire logic [DIST_BITS-1:0] cand_dist,
    input  wire logic [NODE_BITS-1:0] cand_pred,
    output logic                      found,
    output logic      [DIST_BITS-1:0] best_dist,
    output logic      [NODE_BITS-1:0] best_idx,
    output logic      [NODE_BITS-1:0] best_pred
);

    logic                 found_reg;
    logic [DIST_BITS-1:0] best_reg;
    logic [NODE_BITS-1:0] idx_reg;
    logic [NODE_BITS-1:0] pred_reg;
    logic                 take;

    // strict compare keeps the earliest index on a tie
    assign take = ctrl.sample && cand_reached && !cand_done &&
                  (!found_reg || (cand_dist < best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_reg <= cand_dist;
            idx_reg  <= cand_idx;
            pred_reg <= cand_pred;
        end
    end

    assign found     = found_reg;
    assign best_dist = best_reg;
    assign best_idx  = idx_reg;
    assign best_pred = pred_reg;

endmodule

`default_nettype wire

// File: design/dgsp_relax.sv
// ============================================================================
// dgsp_relax - edge relaxation for one neighbor
// Saturating path sum and strict-improvement test against the stored distance.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dgsp_relax
    import dgsp_pkg::*;
#(
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic [DIST_BITS-1:0]   dist_u,
    input  wire logic [WEIGHT_BITS-1:0] weight,
    input  wire logic                   nb_reached,
    input  wire logic                   nb_done,
    input  wire logic [DIST_BITS-1:0]   nb_dist,
    input  wire logic                   skip,
    output relax_res_t                  res
);

    localparam int SUM_BITS = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
    localparam logic [WEIGHT_BITS-1:0] NO_LINK = '1;

    logic [SUM_BITS-1:0]  sum_wide;
    logic [DIST_BITS-1:0] sum_sat;

    // saturating add
    assign sum_wide = SUM_BITS'(dist_u) + SUM_BITS'(weight);
    assign sum_sat  = (sum_wide > SUM_BITS'(DIST_MAX)) ? DIST_MAX : sum_wide[DIST_BITS-1:0];

    // update only on first reach or strict improvement
    assign res.update   = !skip && !nb_done && (weight != NO_LINK) &&
                          (!nb_reached || (sum_sat < nb_dist));
    assign res.new_dist = sum_sat;

endmodule

`default_nettype wire

// File: tb/sv/dense_graph_shortest_path_unit_tb.sv
// ============================================================================
// dense_graph_shortest_path_unit_tb - self-checking bench of the route unit
// Writes edge weights and runs route queries through the request channel.
// Every accepted write updates a local weight copy and every accepted query
// is fed to a local shortest-path predictor. Each streamed route station is
// compared with the oldest expected one. Both channels idle at random, and
// the response side holds off once for a long stretch.
// ============================================================================
`timescale 1ns / 1ps

module dense_graph_shortest_path_unit_tb;
    import dgsp_pkg::*;

    localparam int NODES          = 1 << NODE_FIELD_BITS;
    localparam int RESET_CYCLES   = 7;
    localparam int LONG_STALL     = 400;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int TAIL_CYCLES    = 200;
    localparam int RANDOM_BUDGET  = 45;
    localparam int REPORT_LIMIT   = 10;

    localparam logic                         CMD_QUERY = ~CMD_WRITE;
    localparam logic [WEIGHT_FIELD_BITS-1:0] NO_LINK   = '1;

    typedef struct packed {
        logic [NODE_FIELD_BITS-1:0] node;
        logic [DIST_BITS-1:0]       distance;
        logic                       reachable;
        logic                       last;
    } route_station_t;

    logic clk;
    logic rst_n;

    dgsp_req_if req_ch ();
    dgsp_rsp_if rsp_ch ();

    dense_graph_shortest_path_unit #(
        .NODE_COUNT  (NODES),
        .WEIGHT_BITS (WEIGHT_FIELD_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Local copy of the weight matrix and the stations still to arrive
    logic [WEIGHT_FIELD_BITS-1:0] link_cost [NODES][NODES];
    route_station_t               route_expect_q [$];

    // Shared run controls and statistics
    bit          no_idle;
    bit          stall_armed;
    int unsigned error_count;
    int unsigned write_count;
    int unsigned query_count;
    int unsigned no_route_count;
    int unsigned station_count;
    int unsigned longest_route;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor: array Dijkstra, lowest index wins ties, strict improvement
    // ------------------------------------------------------------------------
    function automatic void predict_route(input logic [NODE_FIELD_BITS-1:0] src,
                                          input logic [NODE_FIELD_BITS-1:0] dst);
        logic [DIST_BITS-1:0]       node_dist [NODES];
        logic [NODE_FIELD_BITS-1:0] pred      [NODES];
        logic [NODE_FIELD_BITS-1:0] walk      [NODES];
        bit                         settled   [NODES];
        bit                         seen      [NODES];
        route_station_t             station;
        logic [NODE_FIELD_BITS-1:0] n;
        int unsigned                sum;
        int                         i;
        int                         u;
        int                         rnd;
        int                         len;
        bit                         found;

        for (i = 0; i < NODES; i++)
        begin
            node_dist[i] = '0;
            pred[i]      = '0;
            settled[i]   = 1'b0;
            seen[i]      = 1'b0;
        end
        seen[src] = 1'b1;
        pred[src] = src;

        for (rnd = 0; rnd < NODES; rnd++)
        begin
            // nearest open node
            found = 1'b0;
            u     = 0;
            for (i = 0; i < NODES; i++)
            begin
                if (seen[i] && !settled[i] && (!found || node_dist[i] < node_dist[u]))
                begin
                    found = 1'b1;
                    u     = i;
                end
            end
            if (!found)
                break;
            settled[u] = 1'b1;

            // relax its row; the start keeps distance 0
            for (i = 0; i < NODES; i++)
            begin
                if (settled[i] || i == src || link_cost[u][i] == NO_LINK)
                    continue;
                sum = 32'(node_dist[u]) + 32'(link_cost[u][i]);
                if (sum > 32'(DIST_MAX))
                    sum = 32'(DIST_MAX);
                if (!seen[i] || sum < 32'(node_dist[i]))
                begin
                    seen[i]      = 1'b1;
                    node_dist[i] = DIST_BITS'(sum);
                    pred[i]      = NODE_FIELD_BITS'(u);
                end
            end
        end

        if (!seen[dst])
        begin
            station = '{node: '0, distance: '0, reachable: 1'b0, last: 1'b1};
            route_expect_q.push_back(station);
            no_route_count++;
            return;
        end

        // walk back from the end, then stream start first
        len = 0;
        n   = dst;
        while (len < NODES)
        begin
            walk[len] = n;
            len++;
            if (n == src)
                break;
            n = pred[n];
        end
        for (i = 0; i < len; i++)
        begin
            station = '{node: walk[len-1-i], distance: node_dist[dst], reachable: 1'b1,
                        last: (i == len - 1)};
            route_expect_q.push_back(station);
        end
        if (len > longest_route)
            longest_route = len;
    endfunction

    function automatic logic [WEIGHT_FIELD_BITS-1:0] draw_weight();
        int unsigned pick;

        pick = $urandom_range(0, 9);
        if (pick < 6)
            return WEIGHT_FIELD_BITS'($urandom_range(1, 15));
        else if (pick == 6)
            return '0;
        else if (pick == 7)
            return NO_LINK;
        else
            return WEIGHT_FIELD_BITS'($urandom_range(0, 65535));
    endfunction

    // Random payload word for queries, where the weight field is unused
    function automatic logic [WEIGHT_FIELD_BITS-1:0] draw_word();
        return WEIGHT_FIELD_BITS'($urandom_range(0, 65535));
    endfunction

    // Any station, or one of the eight stations from base up
    function automatic logic [NODE_FIELD_BITS-1:0] draw_node();
        return NODE_FIELD_BITS'($urandom_range(0, NODES - 1));
    endfunction

    function automatic logic [NODE_FIELD_BITS-1:0] draw_near(
        input logic [NODE_FIELD_BITS-1:0] base);
        return base + NODE_FIELD_BITS'($urandom_range(0, 7));
    endfunction

    // ------------------------------------------------------------------------
    // Send one request; starts and ends at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_request(input logic                         cmd,
                                input logic [NODE_FIELD_BITS-1:0]   src,
                                input logic [NODE_FIELD_BITS-1:0]   dst,
                                input logic [WEIGHT_FIELD_BITS-1:0] weight);
        int unsigned gap;

        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= cmd;
        req_ch.from_node   <= src;
        req_ch.to_node     <= dst;
        req_ch.edge_weight <= weight;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);

        if (cmd == CMD_WRITE)
        begin
            link_cost[src][dst] = weight;
            write_count++;
        end
        else
        begin
            predict_route(src, dst);
            query_count++;
        end
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Fresh graph: nothing linked, only start equals end finds a route
    task automatic test_empty_graph();
        send_request(CMD_QUERY, 5, 9, 16'hFFFF);
        send_request(CMD_QUERY, 0, 0, 16'h0000);
        send_request(CMD_QUERY, 63, 63, 16'hA5A5);
        send_request(CMD_QUERY, 62, 1, 16'h5A5A);
    endtask

    // Zero weight, heaviest weight, and removing a link again
    task automatic test_edge_extremes();
        send_request(CMD_WRITE, 0, 63, 16'h0000);
        send_request(CMD_QUERY, 0, 63, 16'h1234);
        send_request(CMD_WRITE, 63, 0, 16'hFFFE);
        send_request(CMD_QUERY, 63, 0, 16'h0000);
        send_request(CMD_WRITE, 0, 63, NO_LINK);
        send_request(CMD_QUERY, 0, 63, 16'hFFFF);
        send_request(CMD_QUERY, 63, 0, 16'hFFFF);
    endtask

    // Diagonal weights are stored but never used by a query
    task automatic test_diagonal();
        send_request(CMD_WRITE, 7, 7, 16'd1234);
        send_request(CMD_WRITE, 7, 8, 16'd5);
        send_request(CMD_QUERY, 7, 7, 16'h0000);
        send_request(CMD_QUERY, 7, 8, 16'h0000);
        send_request(CMD_WRITE, 8, 8, NO_LINK);
        send_request(CMD_QUERY, 8, 8, 16'h0000);
    endtask

    // Equal-length routes and a zero-weight hop: tie rules pick the route
    task automatic test_equal_paths();
        send_request(CMD_WRITE, 10, 11, 16'd3);
        send_request(CMD_WRITE, 10, 12, 16'd3);
        send_request(CMD_WRITE, 11, 13, 16'd4);
        send_request(CMD_WRITE, 12, 13, 16'd4);
        send_request(CMD_WRITE, 12, 11, 16'd0);
        send_request(CMD_QUERY, 10, 13, 16'h0000);
        send_request(CMD_QUERY, 13, 10, 16'h0000);
    endtask

    // ------------------------------------------------------------------------
    // Chain through all stations in random order: full-length route, heavy
    // weights, and a long hold-off on the response side mid-route
    // ------------------------------------------------------------------------
    task automatic test_long_route();
        logic [NODE_FIELD_BITS-1:0] order [NODES];
        logic [NODE_FIELD_BITS-1:0] tmp;
        int                         i;
        int                         j;

        no_idle = 1'b1;
        // drop every link so the chain is the only route
        for (i = 0; i < NODES; i++)
            for (j = 0; j < NODES; j++)
                if (i != j && link_cost[i][j] != NO_LINK)
                    send_request(CMD_WRITE, NODE_FIELD_BITS'(i), NODE_FIELD_BITS'(j),
                                 NO_LINK);

        for (i = 0; i < NODES; i++)
            order[i] = NODE_FIELD_BITS'(i);
        for (i = NODES - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        no_idle = 1'b0;
        for (i = 0; i < NODES - 1; i++)
            send_request(CMD_WRITE, order[i], order[i+1],
                         WEIGHT_FIELD_BITS'($urandom_range(60000, 65534)));

        // response side stalls after the first station; keep requests coming
        no_idle     = 1'b1;
        stall_armed = 1'b1;
        send_request(CMD_QUERY, order[0], order[NODES-1], draw_word());
        send_request(CMD_QUERY, order[NODES-1], order[0], draw_word());
        send_request(CMD_WRITE, order[3], order[40], draw_weight());
        send_request(CMD_QUERY, order[1], order[50], draw_word());
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly short linked walks followed by a route query,
    // plus loose writes, loose queries and start equals end queries
    // ------------------------------------------------------------------------
    task automatic test_random_traffic(input int unsigned budget);
        logic [NODE_FIELD_BITS-1:0] stop [6];
        logic [NODE_FIELD_BITS-1:0] base;
        int unsigned                sent;
        int unsigned                hops;
        int unsigned                pick;
        int unsigned                k;

        sent = 0;
        while (sent < budget)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            base    = NODE_FIELD_BITS'($urandom_range(0, NODES - 8));
            pick    = $urandom_range(0, 99);
            if (pick < 45)
            begin
                hops    = $urandom_range(1, 5);
                stop[0] = draw_near(base);
                for (k = 1; k <= hops; k++)
                begin
                    stop[k] = draw_near(base);
                    send_request(CMD_WRITE, stop[k-1], stop[k], draw_weight());
                end
                // now and then ask the way back, which often has no route
                if ($urandom_range(0, 4) == 0)
                    send_request(CMD_QUERY, stop[hops], stop[0], draw_word());
                else
                    send_request(CMD_QUERY, stop[0], stop[hops], draw_word());
                sent += hops + 1;
            end
            else if (pick < 70)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_request(CMD_WRITE, draw_node(), draw_node(), draw_weight());
                else
                    send_request(CMD_WRITE, draw_near(base), draw_near(base),
                                 draw_weight());
                sent++;
            end
            else if (pick < 92)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_request(CMD_QUERY, draw_node(), draw_node(), draw_word());
                else
                    send_request(CMD_QUERY, draw_near(base), draw_near(base), draw_word());
                sent++;
            end
            else
            begin
                stop[0] = draw_node();
                send_request(CMD_QUERY, stop[0], stop[0], draw_word());
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Response side: random gap per station, one long hold when armed
    // ------------------------------------------------------------------------
    initial
    begin : rsp_pacing
        int unsigned idle;

        rsp_ch.ready = 1'b0;
        idle         = $urandom_range(0, 4);
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= (idle == 0);
            if (idle != 0)
                idle--;
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (stall_armed)
                begin
                    idle        = LONG_STALL;
                    stall_armed = 1'b0;
                end
                else
                begin
                    idle = no_idle ? 0 : $urandom_range(0, 4);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Station checker
    // ------------------------------------------------------------------------
    initial
    begin : station_check
        route_station_t got;
        route_station_t want;

        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got = '{node: rsp_ch.path_node, distance: rsp_ch.total_distance,
                        reachable: rsp_ch.reachable, last: rsp_ch.last};
                station_count++;
                if (route_expect_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected station node %0d dist %0d reach %0b last %0b",
                                 $realtime, got.node, got.distance, got.reachable, got.last);
                end
                else
                begin
                    want = route_expect_q.pop_front();
                    if (got.node !== want.node || got.distance !== want.distance ||
                        got.reachable !== want.reachable || got.last !== want.last)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: station mismatch, expected node %0d dist %0d %s",
                                     $realtime, want.node, want.distance,
                                     $sformatf("reach %0b last %0b",
                                               want.reachable, want.last));
                            $display("%0t:   got node %0d dist %0d reach %0b last %0b",
                                     $realtime, got.node, got.distance,
                                     got.reachable, got.last);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles in a row with no request and no station moving
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int unsigned quiet;

        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d stations outstanding",
                         $realtime, quiet, route_expect_q.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        int i;
        int j;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_WRITE;
        req_ch.from_node   = '0;
        req_ch.to_node     = '0;
        req_ch.edge_weight = '0;
        no_idle            = 1'b0;
        stall_armed        = 1'b0;
        error_count        = 0;
        write_count        = 0;
        query_count        = 0;
        no_route_count     = 0;
        station_count      = 0;
        longest_route      = 0;
        for (i = 0; i < NODES; i++)
            for (j = 0; j < NODES; j++)
                link_cost[i][j] = (i == j) ? '0 : NO_LINK;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_graph();
        test_edge_extremes();
        test_diagonal();
        test_equal_paths();
        test_long_route();
        test_random_traffic(RANDOM_BUDGET);
        req_ch.valid <= 1'b0;

        while (route_expect_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d edge writes and %0d route queries, %0d of them with no route.",
                 write_count, query_count, no_route_count);
        $display("Checked %0d route stations, longest route %0d stations, %0d mismatches.",
                 station_count, longest_route, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
